@@ rtl/ssw_pkg.sv @@
// Package for the servo sync-write framer: packet constants, byte sequence codes,
// register indexes and the queue entry type.
// No dependencies; imported by every module of the framer.
package ssw_pkg;

   // Widths of the transaction fields and the configuration port.
   localparam int POS_W   = 10;
   localparam int SPD_W   = 10;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;

   // Defaults for the top-level parameters.
   localparam int MAX_SERVOS_DEF  = 32;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Register reset values.
   localparam logic [COUNT_W-1:0] SERVO_COUNT_RST   = 6'd18;
   localparam logic [BYTE_W-1:0]  START_ADDRESS_RST = 8'd30;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SERVO_COUNT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_ADDRESS = 1'd1;

   // Fixed packet bytes.
   localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'hFF;
   localparam logic [BYTE_W-1:0] BCAST_ID   = 8'hFE;
   localparam logic [BYTE_W-1:0] SYNC_INSTR = 8'h83;
   localparam logic [BYTE_W-1:0] DATA_LEN   = 8'h04;

   // Byte positions within the packet, in transmission order.
   typedef enum logic [3:0] {
      STEP_SYNC0  = 4'd0,
      STEP_SYNC1  = 4'd1,
      STEP_BCAST  = 4'd2,
      STEP_LEN    = 4'd3,
      STEP_INSTR  = 4'd4,
      STEP_ADDR   = 4'd5,
      STEP_DLEN   = 4'd6,
      STEP_ID     = 4'd7,
      STEP_POS_LO = 4'd8,
      STEP_POS_HI = 4'd9,
      STEP_SPD_LO = 4'd10,
      STEP_SPD_HI = 4'd11,
      STEP_CSUM   = 4'd12
   } step_type;

   // One classified entry, handed from the front to the back.
   typedef struct packed {
      logic [POS_W-1:0]  goal_position;
      logic [SPD_W-1:0]  move_speed;
      logic              first;
      logic              last;
      logic [BYTE_W-1:0] servo_id;
      logic [BYTE_W-1:0] length;
      logic [BYTE_W-1:0] address;
   } entry_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ rtl/ssw_front.sv @@
// Front end of the servo sync-write framer: configuration registers, entry
// counter and classification of each accepted entry. Depends on ssw_pkg.
module ssw_front #(
   parameter int MAX_SERVOS = ssw_pkg::MAX_SERVOS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [ssw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ssw_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ssw_pkg::POS_W-1:0]         req_goal_position,
   input  logic [ssw_pkg::SPD_W-1:0]         req_move_speed,
   input  ssw_pkg::queue_status_type         q_status,
   output logic                              q_push,
   output ssw_pkg::entry_type                q_entry
);
   import ssw_pkg::*;

   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_SERVOS);

   logic [COUNT_W-1:0] servo_count_ff;
   logic [BYTE_W-1:0]  start_address_ff;
   logic [COUNT_W-1:0] entry_ff, entry_in;
   logic [COUNT_W-1:0] count_eff;
   logic [BYTE_W-1:0]  count_x5;
   logic               is_last;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         servo_count_ff   <= SERVO_COUNT_RST;
         start_address_ff <= START_ADDRESS_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SERVO_COUNT: begin
               servo_count_ff <= csr_write_data[COUNT_W-1:0];
            end
            CSR_START_ADDRESS: begin
               start_address_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // Count in force: zero acts as one, values above the limit saturate.
   always_comb begin
      if (servo_count_ff == '0) begin
         count_eff = COUNT_W'(1);
      end else if (servo_count_ff > MAX_CNT) begin
         count_eff = MAX_CNT;
      end else begin
         count_eff = servo_count_ff;
      end
   end

   assign count_x5 = (BYTE_W'(count_eff) << 2) + BYTE_W'(count_eff);
   assign is_last  = ({1'b0, entry_ff} + 7'd1) >= {1'b0, count_eff};

   // A transaction is taken whenever the queue has room.
   assign req_ready = !q_status.full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      q_entry.goal_position = req_goal_position;
      q_entry.move_speed    = req_move_speed;
      q_entry.first         = (entry_ff == '0);
      q_entry.last          = is_last;
      q_entry.servo_id      = BYTE_W'(entry_ff) + BYTE_W'(1);
      q_entry.length        = count_x5 + DATA_LEN;
      q_entry.address       = start_address_ff;
   end

   // Entry counter wraps at the end of each packet.
   always_comb begin
      entry_in = entry_ff;
      if (q_push) begin
         entry_in = is_last ? '0 : entry_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

@@ rtl/ssw_queue.sv @@
// Small register queue between the front and the back of the framer.
// Depends on ssw_pkg for the entry type.
module ssw_queue #(
   parameter int DEPTH = ssw_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ssw_pkg::entry_type            push_entry,
   input  logic                          pop,
   output ssw_pkg::entry_type            head_entry,
   output ssw_pkg::queue_status_type     status,
   output logic [$clog2(DEPTH+1)-1:0]    fill
);
   import ssw_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   entry_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign status.full  = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_entry   = slot_ff[rd_ptr_ff];
   assign fill         = cnt_ff;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ rtl/ssw_back.sv @@
// Back end of the servo sync-write framer: byte sequencer, checksum
// accumulator and output register. Depends on ssw_pkg.
module ssw_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ssw_pkg::entry_type            head_entry,
   input  ssw_pkg::queue_status_type     q_status,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [ssw_pkg::BYTE_W-1:0]    rsp_tx_byte,
   output logic                          rsp_last_byte
);
   import ssw_pkg::*;

   step_type           step_ff, step_in;
   logic               started_ff, started_in;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic               valid_ff, valid_in;
   logic [BYTE_W-1:0]  byte_ff, byte_in;
   logic               last_ff, last_in;

   step_type           cur_step;
   logic [BYTE_W-1:0]  cur_byte;
   logic               advance;
   logic               emit;
   logic               item_done;
   logic               summed;

   // The output register takes a new byte when empty or being drained.
   assign advance = !valid_ff || rsp_ready;
   assign emit    = advance && !q_status.empty;

   // A fresh entry starts at the header or at its id byte.
   always_comb begin
      if (started_ff) begin
         cur_step = step_ff;
      end else if (head_entry.first) begin
         cur_step = STEP_SYNC0;
      end else begin
         cur_step = STEP_ID;
      end
   end

   // Byte selection for the current position in the packet.
   always_comb begin
      summed = 1'b1;
      case (cur_step)
         STEP_SYNC0: begin
            cur_byte = HDR_BYTE;
            summed   = 1'b0;
         end
         STEP_SYNC1: begin
            cur_byte = HDR_BYTE;
            summed   = 1'b0;
         end
         STEP_BCAST:  cur_byte = BCAST_ID;
         STEP_LEN:    cur_byte = head_entry.length;
         STEP_INSTR:  cur_byte = SYNC_INSTR;
         STEP_ADDR:   cur_byte = head_entry.address;
         STEP_DLEN:   cur_byte = DATA_LEN;
         STEP_ID:     cur_byte = head_entry.servo_id;
         STEP_POS_LO: cur_byte = head_entry.goal_position[7:0];
         STEP_POS_HI: cur_byte = BYTE_W'(head_entry.goal_position[POS_W-1:8]);
         STEP_SPD_LO: cur_byte = head_entry.move_speed[7:0];
         STEP_SPD_HI: cur_byte = BYTE_W'(head_entry.move_speed[SPD_W-1:8]);
         STEP_CSUM: begin
            cur_byte = ~sum_ff;
            summed   = 1'b0;
         end
         default: begin
            cur_byte = '0;
            summed   = 1'b0;
         end
      endcase
   end

   // The entry is finished after its speed byte, or after the checksum.
   assign item_done = (cur_step == STEP_CSUM) ||
                      ((cur_step == STEP_SPD_HI) && !head_entry.last);
   assign q_pop     = emit && item_done;

   // Sequencer and checksum next state.
   always_comb begin
      step_in    = step_ff;
      started_in = started_ff;
      sum_in     = sum_ff;
      if (emit) begin
         if (item_done) begin
            started_in = 1'b0;
         end else begin
            started_in = 1'b1;
            step_in    = step_type'(cur_step + 4'd1);
         end
         if (cur_step == STEP_SYNC0 || cur_step == STEP_CSUM) begin
            sum_in = '0;
         end else if (summed) begin
            sum_in = sum_ff + cur_byte;
         end
      end
   end

   // Output register next state.
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (advance) begin
         valid_in = emit;
         byte_in  = cur_byte;
         last_in  = (cur_step == STEP_CSUM);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff    <= STEP_SYNC0;
         started_ff <= 1'b0;
         sum_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         step_ff    <= step_in;
         started_ff <= started_in;
         sum_ff     <= sum_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_tx_byte   = byte_ff;
   assign rsp_last_byte = last_ff;

endmodule

@@ rtl/servo_sync_write_framer_unit.sv @@
// The first byte of an entry passes through the queue and the output register.
// Throughput: one output byte per cycle unless rsp_ready stalls or the queue is
// empty; the byte sequencer makes an entry 5 bytes, 12 with header, 13 with checksum.
// The two-entry queue lets the front take entries while the back still sends.
// Reset (synchronous, active high) empties the queue, zeroes the entry index
// and checksum, and loads servo_count = 18 and start_address = 30.
module servo_sync_write_framer_unit #(
   parameter int MAX_SERVOS  = ssw_pkg::MAX_SERVOS_DEF,
   parameter int QUEUE_DEPTH = ssw_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [ssw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ssw_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ssw_pkg::POS_W-1:0]         req_goal_position,
   input  logic [ssw_pkg::SPD_W-1:0]         req_move_speed,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [ssw_pkg::BYTE_W-1:0]        rsp_tx_byte,
   output logic                              rsp_last_byte
);
   import ssw_pkg::*;

   logic                              q_push;
   logic                              q_pop;
   entry_type                         q_in_entry;
   entry_type                         q_head_entry;
   queue_status_type                  q_status;
   logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_fill;

   // Front end: configuration and entry classification.
   ssw_front #(
      .MAX_SERVOS(MAX_SERVOS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_goal_position(req_goal_position),
      .req_move_speed   (req_move_speed),
      .q_status         (q_status),
      .q_push           (q_push),
      .q_entry          (q_in_entry)
   );

   // Entry queue between front and back.
   ssw_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in_entry),
      .pop        (q_pop),
      .head_entry (q_head_entry),
      .status     (q_status),
      .fill       (q_fill)
   );

   // Back end: byte sequencing and checksum.
   ssw_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (q_head_entry),
      .q_status     (q_status),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_tx_byte  (rsp_tx_byte),
      .rsp_last_byte(rsp_last_byte)
   );

   // An accepted transaction is waiting in the queue on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !q_status.empty)
      else $error("accepted transaction missing from queue");

   // The fill count never exceeds the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      q_fill <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

   // Finishing an entry always leaves its final byte in the output register.
   assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp_valid)
      else $error("entry retired without an output byte");

   // The checksum byte only ends an entry that was marked last.
   assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_head_entry.last) |=> !rsp_last_byte)
      else $error("end-of-packet flag on a middle entry");

endmodule

@@ dv/ssw_framer_checker.sv @@
`timescale 1ns / 1ps
// Checker for the servo sync-write framer. It watches the register port and both channels,
// predicts the packet bytes and compares them with the byte stream.
// Depends on ssw_pkg for the widths, the fixed packet bytes and the register indexes.
module ssw_framer_checker #(
   parameter int MAX_SERVOS = ssw_pkg::MAX_SERVOS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [ssw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssw_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [ssw_pkg::POS_W-1:0]      req_goal_position,
   input  logic [ssw_pkg::SPD_W-1:0]      req_move_speed,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [ssw_pkg::BYTE_W-1:0]     rsp_tx_byte,
   input  logic                           rsp_last_byte,
   output int                             failures,
   output int                             pending,
   output int                             bytes_checked,
   output int                             packets_closed
);
   import ssw_pkg::*;

   // Bytes per servo entry, and the bytes that the length field counts besides the entries.
   localparam int ENTRY_BYTES     = 5;
   localparam int LEN_FIXED_BYTES = 4;

   typedef struct packed {
      logic [BYTE_W-1:0] tx_byte;
      logic              last_byte;
   } packet_byte_type;

   packet_byte_type expected_bytes[$];

   // Shadow copy of the registers and of the framing state.
   logic [COUNT_W-1:0] servo_count_q;
   logic [BYTE_W-1:0]  start_address_q;
   logic [BYTE_W-1:0]  checksum_acc;
   logic [COUNT_W-1:0] entry_index_q;

   // A count of zero acts as one, and counts above the limit saturate.
   function automatic int unsigned active_count();
      int unsigned c;
      c = servo_count_q;
      if (c < 1) c = 1;
      if (c > MAX_SERVOS) c = MAX_SERVOS;
      return c;
   endfunction

   task automatic queue_byte(input logic [BYTE_W-1:0] b, input logic last, input bit summed);
      packet_byte_type item;
      item.tx_byte   = b;
      item.last_byte = last;
      expected_bytes.push_back(item);
      if (summed) checksum_acc = checksum_acc + b;
   endtask

   // Works out the bytes that one entry transaction puts on the wire.
   task automatic frame_entry(input logic [POS_W-1:0] pos, input logic [SPD_W-1:0] spd);
      int unsigned cnt;
      logic [BYTE_W-1:0] length_byte;
      logic [BYTE_W-1:0] id_byte;
      logic [BYTE_W-1:0] pos_hi;
      logic [BYTE_W-1:0] spd_hi;
      cnt         = active_count();
      length_byte = BYTE_W'(ENTRY_BYTES * cnt + LEN_FIXED_BYTES);
      id_byte     = BYTE_W'(entry_index_q) + BYTE_W'(1);
      pos_hi      = BYTE_W'(pos[POS_W-1:8]);
      spd_hi      = BYTE_W'(spd[SPD_W-1:8]);

      // The first entry of a packet carries the header; the sync bytes are not summed.
      if (entry_index_q == '0) begin
         checksum_acc = '0;
         queue_byte(HDR_BYTE, 1'b0, 1'b0);
         queue_byte(HDR_BYTE, 1'b0, 1'b0);
         queue_byte(BCAST_ID, 1'b0, 1'b1);
         queue_byte(length_byte, 1'b0, 1'b1);
         queue_byte(SYNC_INSTR, 1'b0, 1'b1);
         queue_byte(start_address_q, 1'b0, 1'b1);
         queue_byte(DATA_LEN, 1'b0, 1'b1);
      end

      queue_byte(id_byte, 1'b0, 1'b1);
      queue_byte(pos[7:0], 1'b0, 1'b1);
      queue_byte(pos_hi, 1'b0, 1'b1);
      queue_byte(spd[7:0], 1'b0, 1'b1);
      queue_byte(spd_hi, 1'b0, 1'b1);

      // The entry that reaches the count in force closes the packet with the checksum.
      if (entry_index_q + 1 >= cnt) begin
         queue_byte(~checksum_acc, 1'b1, 1'b0);
         checksum_acc  = '0;
         entry_index_q = '0;
      end else begin
         entry_index_q = entry_index_q + COUNT_W'(1);
      end
   endtask

   always @(posedge clock) begin : watch
      packet_byte_type head;
      if (reset) begin
         servo_count_q   = SERVO_COUNT_RST;
         start_address_q = START_ADDRESS_RST;
         checksum_acc    = '0;
         entry_index_q   = '0;
         expected_bytes.delete();
      end else begin
         // Compare each byte transaction with the oldest expected byte.
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               failures++;
               $display("%0t: unexpected byte 0x%02h (last %0b), expected none",
                        $time, rsp_tx_byte, rsp_last_byte);
            end else begin
               head = expected_bytes.pop_front();
               if (rsp_tx_byte !== head.tx_byte) begin
                  failures++;
                  $display("%0t: tx_byte mismatch, expected 0x%02h, actual 0x%02h",
                           $time, head.tx_byte, rsp_tx_byte);
               end
               if (rsp_last_byte !== head.last_byte) begin
                  failures++;
                  $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                           $time, head.last_byte, rsp_last_byte);
               end
            end
            bytes_checked++;
            if (rsp_last_byte === 1'b1) packets_closed++;
         end

         // Each accepted entry transaction adds its bytes to the expected stream.
         if (req_valid && req_ready) frame_entry(req_goal_position, req_move_speed);

         // Register writes take effect for the following transactions.
         if (csr_write_enable) begin
            if (csr_index == CSR_SERVO_COUNT) servo_count_q = csr_write_data[COUNT_W-1:0];
            else if (csr_index == CSR_START_ADDRESS) start_address_q = csr_write_data;
         end
      end
      pending <= expected_bytes.size();
   end

endmodule

@@ dv/servo_sync_write_framer_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the servo sync-write framer: clock, reset, entry and register stimulus,
// a randomly stalling byte sink and the verdict.
// Depends on ssw_pkg, servo_sync_write_framer_unit and ssw_framer_checker.
module servo_sync_write_framer_unit_tb;
   import ssw_pkg::*;

   localparam int FRAMER_MAX_SERVOS = MAX_SERVOS_DEF;
   localparam int RANDOM_ENTRIES    = 150;
   localparam int HOLD_CYCLES       = 200;
   localparam int DRAIN_CYCLES      = 20;
   localparam int MAX_GAP           = 13;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [POS_W-1:0]      req_goal_position = '0;
   logic [SPD_W-1:0]      req_move_speed = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [BYTE_W-1:0]     rsp_tx_byte;
   logic                  rsp_last_byte;

   int failures;
   int pending;
   int bytes_checked;
   int packets_closed;
   int entries_sent = 0;
   int csr_writes = 0;

   // Shared between stimulus and sink: no idling at all, and a request for a long hold-off.
   bit steady = 1'b0;
   bit hold_request = 1'b0;

   servo_sync_write_framer_unit #(
      .MAX_SERVOS(FRAMER_MAX_SERVOS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_goal_position(req_goal_position),
      .req_move_speed(req_move_speed),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_last_byte(rsp_last_byte)
   );

   ssw_framer_checker #(
      .MAX_SERVOS(FRAMER_MAX_SERVOS)
   ) u_checker (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_goal_position(req_goal_position),
      .req_move_speed(req_move_speed),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_tx_byte(rsp_tx_byte),
      .rsp_last_byte(rsp_last_byte),
      .failures(failures),
      .pending(pending),
      .bytes_checked(bytes_checked),
      .packets_closed(packets_closed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offers one entry after a random gap (none if steady), returns at the edge accepting it.
   task automatic send_entry(input logic [POS_W-1:0] pos, input logic [SPD_W-1:0] spd);
      int gap;
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_goal_position <= pos;
      req_move_speed    <= spd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      entries_sent++;
   endtask

   // Mostly random values, with the field extremes now and then.
   function automatic logic [POS_W-1:0] pick_field();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return POS_W'($urandom_range(0, 1023));
   endfunction

   task automatic send_entries(input int n);
      repeat (n) send_entry(pick_field(), pick_field());
   endtask

   // Stops offering entries and waits until every expected byte has been delivered.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      csr_writes++;
   endtask

   // Number of entries that make one complete packet for a count register value.
   function automatic int entries_for(input logic [CSR_DATA_W-1:0] data);
      int c;
      c = data[COUNT_W-1:0];
      if (c == 0) return 1;
      if (c > FRAMER_MAX_SERVOS) return FRAMER_MAX_SERVOS;
      return c;
   endfunction

   // Byte sink: a random stall before each byte transaction, or one long hold-off on request.
   initial begin : byte_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int random_target;
      int pick;
      int n;
      logic [CSR_DATA_W-1:0] count_data;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: the first entry opens an 18-entry packet at address 30.
      send_entry('0, '1);
      // Zero count acts as one and also closes the packet left open.
      settle();
      write_reg(CSR_SERVO_COUNT, 8'd0);
      send_entry('1, '0);
      // Two-entry packet whose address changes after the header went out.
      settle();
      write_reg(CSR_SERVO_COUNT, 8'd2);
      write_reg(CSR_START_ADDRESS, 8'd0);
      send_entry(10'h155, 10'h2AA);
      settle();
      write_reg(CSR_START_ADDRESS, 8'hFF);
      send_entry(10'h2AA, 10'h155);
      send_entry('1, '1);
      send_entry(10'h001, 10'h200);
      // A count far above the limit saturates; then the count drops mid-packet.
      settle();
      write_reg(CSR_SERVO_COUNT, 8'hFF);
      send_entry(10'h0FF, 10'h300);
      settle();
      write_reg(CSR_SERVO_COUNT, 8'h01);
      send_entry(10'h100, 10'h0FF);
      // Bits above the count field are dropped, leaving zero.
      settle();
      write_reg(CSR_SERVO_COUNT, 8'h40);
      send_entry(10'h3FE, 10'h001);
      // Back-to-back entries with no idling on either side.
      settle();
      write_reg(CSR_SERVO_COUNT, 8'd3);
      steady = 1'b1;
      send_entries(3);
      steady = 1'b0;

      // Long sink hold-off while entries keep coming, so the input stalls.
      settle();
      write_reg(CSR_SERVO_COUNT, 8'd6);
      hold_request = 1'b1;
      steady = 1'b1;
      send_entries(12);
      steady = 1'b0;

      // Random packets, mostly small and complete; some cut short before a register change.
      random_target = entries_sent + RANDOM_ENTRIES;
      while (entries_sent < random_target) begin
         settle();
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            count_data = CSR_DATA_W'($urandom_range(32, 255));
         end else if (pick < 12) begin
            count_data = '0;
            count_data[7:6] = 2'($urandom_range(0, 3));
         end else begin
            count_data = CSR_DATA_W'($urandom_range(1, 6));
            count_data[7:6] = 2'($urandom_range(0, 3));
         end
         write_reg(CSR_SERVO_COUNT, count_data);
         if ($urandom_range(0, 2) != 0) begin
            write_reg(CSR_START_ADDRESS, CSR_DATA_W'($urandom_range(0, 255)));
         end
         steady = ($urandom_range(0, 5) == 0);
         n = entries_for(count_data);
         if (n > 1 && $urandom_range(0, 4) == 0) n = $urandom_range(1, n - 1);
         send_entries(n);
         steady = 1'b0;
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d servo entries and %0d register writes;", entries_sent, csr_writes);
      $display("checked %0d packet bytes across %0d closed packets.",
               bytes_checked, packets_closed);
      if (failures == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

@@ files.f @@
rtl/ssw_pkg.sv
rtl/ssw_front.sv
rtl/ssw_queue.sv
rtl/ssw_back.sv
rtl/servo_sync_write_framer_unit.sv
dv/ssw_framer_checker.sv
dv/servo_sync_write_framer_unit_tb.sv
